// ===== rtl/core/longest_valid_paren_run_core_assert.svh =====
// Assertion macros shared by the longest balanced parenthesis run core.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef LONGEST_VALID_PAREN_RUN_CORE_ASSERT_SVH
`define LONGEST_VALID_PAREN_RUN_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LVPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LVPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lvpr_pkg.sv =====
// Shared types and constants for the longest balanced parenthesis run core.
// Has no dependencies; used by longest_valid_paren_run_core.
`timescale 1ns / 1ps
`default_nettype none

package lvpr_pkg;

    typedef logic [7:0] t_symbol;
    typedef logic [8:0] t_best;

    // Character code of an open parenthesis.
    localparam t_symbol OPEN_CHAR = 8'd40;

endpackage

`default_nettype wire

// ===== rtl/core/lvpr_stack_ram.sv =====
// Position stack storage: one write port, one read port with registered data.
// No dependencies on other project files.
`timescale 1ns / 1ps
`default_nettype none

module lvpr_stack_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/longest_valid_paren_run_core.sv =====
// Top level of the longest balanced parenthesis run core.
// Depends on lvpr_pkg, lvpr_stack_ram and longest_valid_paren_run_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// The core reads a string one character word at a time and returns, for every
// word, the length of the longest balanced run of parentheses seen so far in
// that string. An open parenthesis pushes its position on a stack; any other
// byte pops, and either measures a run against the new top or, when only the
// base mark was popped, makes its own position the new base. A word with
// i_last set closes the string: its result carries o_end_of_string and all
// string state is cleared for the next one. Characters past MAX_LEN are not
// processed and raise o_too_long on that result and on the rest of the string.
// Throughput is one word per clock cycle while the result side is not stalled.
// An accepted word is held in the input register and its result is then loaded
// into the result register, which offers it on the result channel.
// A stalled result holds the input register, and o_in_stall follows i_out_stall
// in the same cycle. The pace is set by the stack RAM: its read is addressed
// from the next stack pointer, so the entry below the top is already
// registered when the next character pops. Entry zero of the stack lives in a
// flip-flop, so no clearing pass is needed after reset or between strings.
module longest_valid_paren_run_core #(
    parameter int MAX_LEN = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire lvpr_pkg::t_symbol    i_symbol,
    input  wire logic                 i_last,
    // Result channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output lvpr_pkg::t_best           o_best_length,
    output logic                      o_too_long,
    output logic                      o_end_of_string
);

    // Positions are stored plus one, so zero is the minus-one base mark and
    // the largest stored value is MAX_LEN.
    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);

    // Input register.
    logic              r_in_valid;
    lvpr_pkg::t_symbol r_in_symbol;
    logic              r_in_last;

    // String state. Stack entry zero is held in r_base; entries one and up
    // live in the RAM at address (index - 1).
    logic [POS_W-1:0]  r_sp, n_sp;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_best, n_best;
    logic [POS_W-1:0]  r_base, n_base;
    logic              r_overflow, n_overflow;

    // Result register.
    logic              r_out_valid;
    lvpr_pkg::t_best   r_out_best, n_out_best;
    logic              r_out_too_long, n_out_too_long;
    logic              r_out_last;

    // Stack RAM port signals.
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [POS_W-1:0]  mark;
    logic [ADDR_W-1:0] rd_addr;
    logic [POS_W-1:0]  mem_q;

    logic              adv;
    logic              in_load;
    logic [POS_W-1:0]  below;
    logic [POS_W-1:0]  run;

    // Terms used by the checks at the end of the module.
    logic              last_adv;
    logic              str_clear;
    logic              out_held;

    // The word in the input register moves on whenever the result register
    // is empty or being emptied in this cycle.
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_load    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_symbol <= i_symbol;
            r_in_last   <= i_last;
        end
    end

    // The RAM always holds stack[r_sp - 1] on mem_q once r_sp is at least
    // two; at exactly one the entry below the top is the base register.
    assign below = (r_sp == POS_W'(1)) ? r_base : mem_q;
    assign run   = mark - below;
    assign mark  = r_pos + POS_W'(1);

    always_comb begin
        n_sp           = r_sp;
        n_pos          = r_pos;
        n_best         = r_best;
        n_base         = r_base;
        n_overflow     = r_overflow;
        wr_en          = 1'b0;
        wr_addr        = ADDR_W'(r_sp);
        n_out_best     = r_out_best;
        n_out_too_long = r_out_too_long;

        if (adv) begin
            if (r_pos < POS_W'(MAX_LEN)) begin
                n_pos = mark;
                if (r_in_symbol == lvpr_pkg::OPEN_CHAR) begin
                    // Push; the new top lands at RAM address r_sp.
                    if (r_sp < POS_W'(MAX_LEN)) begin
                        n_sp  = r_sp + POS_W'(1);
                        wr_en = 1'b1;
                    end
                end else if (r_sp == '0) begin
                    // Only the base was there: this position becomes the base.
                    n_base = mark;
                end else begin
                    n_sp = r_sp - POS_W'(1);
                    if (run > r_best) begin
                        n_best = run;
                    end
                end
            end else begin
                n_overflow = 1'b1;
            end

            n_out_best     = lvpr_pkg::t_best'(n_best);
            n_out_too_long = n_overflow;

            if (r_in_last) begin
                n_sp       = '0;
                n_pos      = '0;
                n_best     = '0;
                n_base     = '0;
                n_overflow = 1'b0;
            end
        end
    end

    // Read the entry that will sit below the top after this edge.
    assign rd_addr = ADDR_W'(n_sp - POS_W'(2));

    lvpr_stack_ram #(
        .DEPTH  (MAX_LEN),
        .DATA_W (POS_W)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (mark),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_pos      <= '0;
            r_best     <= '0;
            r_base     <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_sp       <= n_sp;
            r_pos      <= n_pos;
            r_best     <= n_best;
            r_base     <= n_base;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_best     <= n_out_best;
            r_out_too_long <= n_out_too_long;
            r_out_last     <= r_in_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_best_length   = r_out_best;
    assign o_too_long      = r_out_too_long;
    assign o_end_of_string = r_out_last;

    assign last_adv  = adv && r_in_last;
    assign str_clear = (r_sp == '0) && (r_pos == '0) && (r_best == '0) && !r_overflow;
    assign out_held  = r_out_valid && i_out_stall;

`include "longest_valid_paren_run_core_assert.svh"

    // Every stack entry above the base was pushed by a character of its own.
    `LVPR_ASSERT_NOW(a_sp_within_pos, i_clk, i_rst_n, 1'b1, r_sp <= r_pos, "stack too deep")
    // A balanced run cannot be longer than the characters taken so far.
    `LVPR_ASSERT_NOW(a_best_within_pos, i_clk, i_rst_n, 1'b1, r_best <= r_pos, "best too long")
    // Closing a string leaves the stack, position and best cleared.
    `LVPR_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, last_adv, str_clear, "state not cleared")
    // A result that is held back must not be overwritten by the next word.
    `LVPR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, out_held, !adv, "result overwritten")

endmodule

`default_nettype wire

// ===== tb/sv/tb_longest_valid_paren_run_core.sv =====
// Self-checking testbench for longest_valid_paren_run_core.
// Depends on lvpr_pkg and the core RTL. It runs directed words and then random
// strings; results are checked against typed rows or a position-stack predictor.
`timescale 1ns / 1ps

module tb_longest_valid_paren_run_core;

    localparam int                STR_LIMIT    = 256;
    localparam int                RANDOM_WORDS = 1600;
    localparam int                STALL_LIMIT  = 2000;
    localparam lvpr_pkg::t_symbol OPEN_SYM     = lvpr_pkg::OPEN_CHAR;
    localparam lvpr_pkg::t_symbol CLOSE_CHAR   = 8'd41;

    typedef struct packed {
        lvpr_pkg::t_best best_length;
        logic            too_long;
        logic            end_of_string;
    } t_run_result;

    // One directed word. When typed is set, the expected result is taken from
    // the row itself; otherwise the predictor supplies it.
    typedef struct packed {
        lvpr_pkg::t_symbol sym;
        logic              lst;
        logic              typed;
        lvpr_pkg::t_best   best_length;
        logic              too_long;
    } t_directed_word;

    localparam int N_DIRECTED = 22;

    t_directed_word directed_words [N_DIRECTED] = '{
        // Open, close, then a close that pops the base and becomes the new base.
        '{OPEN_SYM,   1'b0, 1'b1, 9'd0, 1'b0},
        '{CLOSE_CHAR, 1'b0, 1'b1, 9'd2, 1'b0},
        '{CLOSE_CHAR, 1'b0, 1'b1, 9'd2, 1'b0},
        '{OPEN_SYM,   1'b0, 1'b1, 9'd2, 1'b0},
        '{8'h00,      1'b0, 1'b0, 9'd0, 1'b0},
        '{8'hFF,      1'b1, 1'b0, 9'd0, 1'b0},
        // Strings of a single word.
        '{8'hFF,      1'b1, 1'b1, 9'd0, 1'b0},
        '{OPEN_SYM,   1'b1, 1'b1, 9'd0, 1'b0},
        // Nested pair.
        '{OPEN_SYM,   1'b0, 1'b1, 9'd0, 1'b0},
        '{OPEN_SYM,   1'b0, 1'b1, 9'd0, 1'b0},
        '{CLOSE_CHAR, 1'b0, 1'b1, 9'd2, 1'b0},
        '{CLOSE_CHAR, 1'b1, 1'b1, 9'd4, 1'b0},
        // Bytes next to the open code and its bit inverse all act as closers.
        '{CLOSE_CHAR, 1'b0, 1'b0, 9'd0, 1'b0},
        '{OPEN_SYM,   1'b0, 1'b0, 9'd0, 1'b0},
        '{OPEN_SYM,   1'b0, 1'b0, 9'd0, 1'b0},
        '{CLOSE_CHAR, 1'b0, 1'b0, 9'd0, 1'b0},
        '{8'h27,      1'b0, 1'b0, 9'd0, 1'b0},
        '{CLOSE_CHAR, 1'b0, 1'b0, 9'd0, 1'b0},
        '{OPEN_SYM,   1'b0, 1'b0, 9'd0, 1'b0},
        '{8'hD7,      1'b0, 1'b0, 9'd0, 1'b0},
        '{OPEN_SYM,   1'b0, 1'b0, 9'd0, 1'b0},
        '{CLOSE_CHAR, 1'b1, 1'b0, 9'd0, 1'b0}
    };

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    lvpr_pkg::t_symbol i_symbol    = '0;
    logic              i_last      = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    lvpr_pkg::t_best   o_best_length;
    logic              o_too_long;
    logic              o_end_of_string;

    longest_valid_paren_run_core #(
        .MAX_LEN(STR_LIMIT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_symbol       (i_symbol),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_best_length  (o_best_length),
        .o_too_long     (o_too_long),
        .o_end_of_string(o_end_of_string)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Predictor state. Each stack entry holds position + 1, so zero is the
    // minus-one base mark below every open position.
    logic [8:0]      mark_stack [0:STR_LIMIT];
    int              top_idx;
    int              char_count;
    lvpr_pkg::t_best best_run;
    logic            overflow_flag;

    t_run_result       pending_runs [$];
    lvpr_pkg::t_symbol string_buf [$];

    int   error_count      = 0;
    int   words_sent       = 0;
    int   strings_closed   = 0;
    int   results_seen     = 0;
    int   overflow_results = 0;
    int   peak_best        = 0;
    int   stall_cycles     = 0;
    int   hold             = 0;
    bit   send_calm        = 1'b0;
    logic out_calm         = 1'b0;

    function automatic void clear_string();
        foreach (mark_stack[i]) mark_stack[i] = '0;
        top_idx       = 0;
        char_count    = 0;
        best_run      = '0;
        overflow_flag = 1'b0;
    endfunction

    // Advance the predictor by one character and return the result it owes.
    function automatic t_run_result advance_string(lvpr_pkg::t_symbol sym, logic lst);
        t_run_result res;
        logic [8:0]  mark;
        logic [8:0]  run;
        if (char_count < STR_LIMIT) begin
            mark = 9'(char_count + 1);
            if (sym == OPEN_SYM) begin
                if (top_idx < STR_LIMIT) begin
                    top_idx++;
                    mark_stack[top_idx] = mark;
                end
            end else if (top_idx == 0) begin
                // Only the base was on the stack: this close becomes the base.
                mark_stack[0] = mark;
            end else begin
                top_idx--;
                run = mark - mark_stack[top_idx];
                if (run > best_run) best_run = run;
            end
            char_count++;
        end else begin
            overflow_flag = 1'b1;
        end
        res.best_length   = best_run;
        res.too_long      = overflow_flag;
        res.end_of_string = lst;
        if (lst) clear_string();
        return res;
    endfunction

    // Fill string_buf with len characters. Balanced strings, noise aside, only close
    // when something is open and are topped up with closers past len at the end.
    function automatic void build_string(int len, int noise_pct, bit balanced);
        int depth;
        depth = 0;
        string_buf.delete();
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                string_buf.push_back(lvpr_pkg::t_symbol'($urandom_range(0, 255)));
            end else if ((balanced && depth == 0) || $urandom_range(0, 1) == 1) begin
                string_buf.push_back(OPEN_SYM);
                depth++;
            end else begin
                string_buf.push_back(CLOSE_CHAR);
                if (depth > 0) depth--;
            end
        end
        if (balanced) begin
            while (depth > 0) begin
                string_buf.push_back(CLOSE_CHAR);
                depth--;
            end
        end
    endfunction

    // Present one word after a random gap, wait for it to be taken, and
    // queue the result it should produce.
    task automatic send_word(input lvpr_pkg::t_symbol sym, input logic lst,
                             input bit typed, input t_run_result typed_res);
        int          gap;
        t_run_result want;
        gap = send_calm ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        i_last     <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = advance_string(sym, lst);
        if (typed) want = typed_res;
        pending_runs.push_back(want);
        words_sent++;
    endtask

    task automatic send_string();
        t_run_result none;
        none = '0;
        foreach (string_buf[i]) begin
            send_word(string_buf[i], i == string_buf.size() - 1, 1'b0, none);
        end
    endtask

    // Hold the input side idle until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_runs.size() != 0) @(posedge i_clk);
    endtask

    // Result side: check each accepted word, then stall for a random count.
    always @(posedge i_clk) begin
        t_run_result want;
        if (!i_rst_n) begin
            hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_runs.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result best=%0d too_long=%0b end=%0b", $time,
                             o_best_length, o_too_long, o_end_of_string);
                end else begin
                    want = pending_runs.pop_front();
                    if (o_best_length !== want.best_length) begin
                        error_count++;
                        $display("%0t: best_length expected %0d, got %0d", $time,
                                 want.best_length, o_best_length);
                    end
                    if (o_too_long !== want.too_long) begin
                        error_count++;
                        $display("%0t: too_long expected %0b, got %0b", $time,
                                 want.too_long, o_too_long);
                    end
                    if (o_end_of_string !== want.end_of_string) begin
                        error_count++;
                        $display("%0t: end_of_string expected %0b, got %0b", $time,
                                 want.end_of_string, o_end_of_string);
                    end
                end
                if (o_best_length > peak_best) peak_best = o_best_length;
                if (o_too_long) overflow_results++;
                if (o_end_of_string) strings_closed++;
                hold = out_calm ? 0 : $urandom_range(0, 17);
            end else if (hold > 0) begin
                hold--;
            end
            i_out_stall <= (hold != 0);
        end
    end

    // Watchdog: too many cycles in a row with no word moving on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_run_result typed_res;
        int          string_no;
        int          kind;
        clear_string();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_words[i]) begin
            typed_res.best_length   = directed_words[i].best_length;
            typed_res.too_long      = directed_words[i].too_long;
            typed_res.end_of_string = directed_words[i].lst;
            send_word(directed_words[i].sym, directed_words[i].lst,
                      directed_words[i].typed, typed_res);
        end
        drain_results();

        string_no = 0;
        while (words_sent < N_DIRECTED + RANDOM_WORDS) begin
            send_calm = ($urandom_range(0, 5) == 0);
            out_calm <= ($urandom_range(0, 5) == 0);
            if (string_no == 8) begin
                // Deepest run: every open first, then every close, and a few
                // ignored words past the limit, the last of them closing.
                string_buf.delete();
                repeat (STR_LIMIT / 2) string_buf.push_back(OPEN_SYM);
                repeat (STR_LIMIT / 2) string_buf.push_back(CLOSE_CHAR);
                repeat (6) string_buf.push_back(lvpr_pkg::t_symbol'($urandom_range(0, 255)));
            end else if (string_no == 40) begin
                build_string(STR_LIMIT, 5, 1'b0);      // exactly at the limit
            end else if (string_no == 75) begin
                build_string($urandom_range(STR_LIMIT + 1, STR_LIMIT + 8), 10, 1'b0);
            end else begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    build_string($urandom_range(1, 12), 0, 1'b1);
                end else if (kind < 7) begin
                    build_string($urandom_range(1, 30), 0, 1'b0);
                end else if (kind == 7) begin
                    build_string($urandom_range(1, 12), 100, 1'b0);
                end else if (kind == 8) begin
                    build_string($urandom_range(2, 20), 8, 1'b1);
                end else begin
                    build_string($urandom_range(30, 60), 3, 1'b1);
                end
            end
            send_string();
            string_no++;
            if (string_no % 25 == 0) drain_results();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_runs.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_runs.size());
        end

        $display("Sent %0d words in %0d strings; %0d results checked.", words_sent,
                 strings_closed, results_seen);
        $display("Longest run seen %0d; %0d results flagged past the length limit.",
                 peak_best, overflow_results);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
